FILE: hw/rtl/lap_time_statistics_core_assert.svh
// Assertion macros used by the lap timer checker
`ifndef LAP_TIME_STATISTICS_CORE_ASSERT_SVH
`define LAP_TIME_STATISTICS_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LTS_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define LTS_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/lts_pkg.sv
// Package: widths, codes and sizes of the lap timer
package lts_pkg;
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TIME_W   = 48;
    localparam int DUR_W    = 40;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = DUR_W + CNT_W;
    localparam int ACC_W    = 2 * DUR_W + CNT_W;
    localparam int HALF_W   = DUR_W / 2;
    localparam int SQ_W     = 2 * (DUR_W + 2);
    localparam int ROOT_W   = DUR_W + 2;
    localparam int SREM_W   = ROOT_W + 2;
    localparam int DREM_W   = CNT_W + 1;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_LAP     = 2'd1,
        CMD_REPORT  = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
endpackage

FILE: hw/rtl/lts_if.sv
// Handshake interfaces for the command and result channels
interface lts_req_if;
    import lts_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [TIME_W-1:0] now_ns;
    modport source (output valid, command, now_ns, input ready);
    modport sink   (input valid, command, now_ns, output ready);
endinterface

interface lts_rsp_if;
    import lts_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [COUNT_W-1:0] lap_count;
    logic [DUR_W-1:0]   min_ns;
    logic [DUR_W-1:0]   max_ns;
    logic [DUR_W-1:0]   mean_ns;
    logic [DUR_W-1:0]   median_ns;
    logic [DUR_W-1:0]   stddev_ns;
    modport source (output valid, status, lap_count, min_ns, max_ns, mean_ns, median_ns,
                    stddev_ns, input ready);
    modport sink   (input valid, status, lap_count, min_ns, max_ns, mean_ns, median_ns,
                    stddev_ns, output ready);
endinterface

FILE: hw/rtl/lap_time_statistics_core.sv
// Lap timer with min, max, mean, median and deviation over a lap store
//
// req carries a command and a 48-bit nanosecond timestamp; rsp returns
// one result per report, or per lap that finds the store full.
// Restart and a lap that fits give no result.
// A report walks the lap store through one registered read port:
//   scan for min/max/sum, mean division, median selection,
//   squared deviations (one 20x20 multiplier used three times
//   per lap), variance division, square root.
// The median selection dominates the run time of a report, and the
// block takes no transfer while a report is running.
// A result sits in an output register; a further transfer is taken only
// once that register is free or draining, so a stalled receiver holds
// the block. Reset clears the start time and the lap count; the store
// itself needs no clearing.
module lap_time_statistics_core (
    input  logic        clk,
    input  logic        rst_n,
    lts_req_if.sink     req,
    lts_rsp_if.source   rsp
);
    import lts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_P1_RD, S_P1_USE, S_DIV, S_MI_RD, S_MI_USE, S_MJ_RD, S_MJ_USE,
        S_MEVAL, S_V_RD, S_V_USE, S_V_MUL, S_V_ACC, S_SQRT, S_FINISH
    } state_t;

    logic [DUR_W-1:0] mem [CAPACITY];
    logic [DUR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [DUR_W-1:0] mem_wdata;

    state_t            state_reg;
    logic [TIME_W-1:0] start_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  idx_reg, jdx_reg, lt_reg, le_reg;
    logic [DUR_W-1:0]  min_reg, max_reg, mean_reg, cand_reg, meda_reg, medb_reg, d_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [1:0]        msel_reg;
    logic [2*HALF_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg, num_reg;
    logic [DREM_W-1:0] rem_reg;
    logic [6:0]        dcnt_reg;
    logic              var_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SREM_W-1:0] srem_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [DUR_W-1:0]   out_min_reg, out_max_reg, out_mean_reg, out_med_reg, out_sd_reg;

    logic              slot_free, accept, out_set;
    logic [CNT_W-1:0]  idx_inc, jdx_inc, k1, k2;
    logic              idx_last, jdx_last;
    logic [TIME_W-1:0] dur_raw;
    logic [DUR_W-1:0]  dur_sat;
    logic [DREM_W:0]   div_r;
    logic              div_ge;
    logic [DREM_W-1:0] div_rem_next;
    logic [ACC_W-1:0]  div_num_next;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [ACC_W-1:0]  acc_add;
    logic [SREM_W-1:0] sq_r, sq_trial;
    logic              sq_ge;
    logic [DUR_W:0]    med_sum;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    // a new result is loaded into the output register this cycle
    assign out_set = (accept
                      && (((cmd_t'(req.command) == CMD_LAP) && (held_reg >= CNT_W'(CAPACITY)))
                          || ((cmd_t'(req.command) == CMD_REPORT) && (held_reg == '0))))
                     || ((state_reg == S_FINISH) && slot_free);

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign jdx_inc  = jdx_reg + CNT_W'(1);
    assign idx_last = (idx_inc == held_reg);
    assign jdx_last = (jdx_inc == held_reg);
    assign k1 = (held_reg - CNT_W'(1)) >> 1;
    assign k2 = held_reg >> 1;

    assign dur_raw = req.now_ns - start_reg;
    assign dur_sat = (|dur_raw[TIME_W-1:DUR_W]) ? {DUR_W{1'b1}} : dur_raw[DUR_W-1:0];

    assign mem_we    = accept && (cmd_t'(req.command) == CMD_LAP)
                       && (held_reg < CNT_W'(CAPACITY));
    assign mem_wdata = dur_sat;
    assign rd_addr   = (state_reg == S_MJ_RD) ? jdx_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[held_reg[IDX_W-1:0]] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // shared restoring divider, one quotient bit per cycle
    assign div_r        = {rem_reg, num_reg[ACC_W-1]};
    assign div_ge       = div_r >= {2'b00, held_reg};
    assign div_rem_next = div_ge ? DREM_W'(div_r - {2'b00, held_reg}) : DREM_W'(div_r);
    assign div_num_next = {num_reg[ACC_W-2:0], div_ge};

    always_comb
    begin
        case (msel_reg)
            2'd0:    begin mul_a = d_reg[HALF_W-1:0];      mul_b = d_reg[HALF_W-1:0];      end
            2'd1:    begin mul_a = d_reg[HALF_W-1:0];      mul_b = d_reg[DUR_W-1:HALF_W]; end
            default: begin mul_a = d_reg[DUR_W-1:HALF_W]; mul_b = d_reg[DUR_W-1:HALF_W]; end
        endcase
    end

    always_comb
    begin
        case (msel_reg)
            2'd0:    acc_add = ACC_W'(prod_reg);
            2'd1:    acc_add = ACC_W'(prod_reg) << (HALF_W + 1);
            default: acc_add = ACC_W'(prod_reg) << DUR_W;
        endcase
    end

    assign sq_r     = {srem_reg[SREM_W-3:0], num_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_r >= sq_trial;
    assign med_sum  = {1'b0, meda_reg} + {1'b0, medb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_reg      <= '0;
            held_reg       <= '0;
            idx_reg        <= '0;
            jdx_reg        <= '0;
            lt_reg         <= '0;
            le_reg         <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            mean_reg       <= '0;
            cand_reg       <= '0;
            meda_reg       <= '0;
            medb_reg       <= '0;
            d_reg          <= '0;
            sum_reg        <= '0;
            msel_reg       <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            num_reg        <= '0;
            rem_reg        <= '0;
            dcnt_reg       <= '0;
            var_reg        <= 1'b0;
            root_reg       <= '0;
            srem_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_count_reg  <= '0;
            out_min_reg    <= '0;
            out_max_reg    <= '0;
            out_mean_reg   <= '0;
            out_med_reg    <= '0;
            out_sd_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !out_set)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_t'(req.command))
                            CMD_RESTART:
                            begin
                                start_reg <= req.now_ns;
                                held_reg  <= '0;
                            end
                            CMD_LAP:
                            begin
                                if (held_reg < CNT_W'(CAPACITY))
                                begin
                                    held_reg  <= held_reg + CNT_W'(1);
                                    start_reg <= req.now_ns;
                                end
                                else
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= ST_FULL;
                                    out_count_reg  <= COUNT_W'(held_reg);
                                    out_min_reg    <= '0;
                                    out_max_reg    <= '0;
                                    out_mean_reg   <= '0;
                                    out_med_reg    <= '0;
                                    out_sd_reg     <= '0;
                                end
                            end
                            CMD_REPORT:
                            begin
                                if (held_reg == '0)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= ST_EMPTY;
                                    out_count_reg  <= '0;
                                    out_min_reg    <= '0;
                                    out_max_reg    <= '0;
                                    out_mean_reg   <= '0;
                                    out_med_reg    <= '0;
                                    out_sd_reg     <= '0;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    min_reg   <= {DUR_W{1'b1}};
                                    max_reg   <= '0;
                                    sum_reg   <= '0;
                                    state_reg <= S_P1_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_P1_RD:
                    state_reg <= S_P1_USE;
                S_P1_USE:
                begin
                    if (rd_data_reg < min_reg) min_reg <= rd_data_reg;
                    if (rd_data_reg > max_reg) max_reg <= rd_data_reg;
                    idx_reg <= idx_inc;
                    if (idx_last)
                    begin
                        num_reg   <= ACC_W'(sum_reg + SUM_W'(rd_data_reg));
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        var_reg   <= 1'b0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        sum_reg   <= sum_reg + SUM_W'(rd_data_reg);
                        state_reg <= S_P1_RD;
                    end
                end
                S_DIV:
                begin
                    num_reg  <= div_num_next;
                    rem_reg  <= div_rem_next;
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (dcnt_reg == 7'(ACC_W - 1))
                    begin
                        dcnt_reg <= '0;
                        if (!var_reg)
                        begin
                            mean_reg  <= div_num_next[DUR_W-1:0];
                            idx_reg   <= '0;
                            state_reg <= S_MI_RD;
                        end
                        else
                        begin
                            root_reg  <= '0;
                            srem_reg  <= '0;
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_MI_RD:
                    state_reg <= S_MI_USE;
                S_MI_USE:
                begin
                    cand_reg  <= rd_data_reg;
                    jdx_reg   <= '0;
                    lt_reg    <= '0;
                    le_reg    <= '0;
                    state_reg <= S_MJ_RD;
                end
                S_MJ_RD:
                    state_reg <= S_MJ_USE;
                S_MJ_USE:
                begin
                    if (rd_data_reg < cand_reg)  lt_reg <= lt_reg + CNT_W'(1);
                    if (rd_data_reg <= cand_reg) le_reg <= le_reg + CNT_W'(1);
                    jdx_reg   <= jdx_inc;
                    state_reg <= jdx_last ? S_MEVAL : S_MJ_RD;
                end
                S_MEVAL:
                begin
                    if (lt_reg <= k1 && k1 < le_reg) meda_reg <= cand_reg;
                    if (lt_reg <= k2 && k2 < le_reg) medb_reg <= cand_reg;
                    if (idx_last)
                    begin
                        idx_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_V_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_MI_RD;
                    end
                end
                S_V_RD:
                    state_reg <= S_V_USE;
                S_V_USE:
                begin
                    d_reg     <= (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                                           : mean_reg - rd_data_reg;
                    msel_reg  <= 2'd0;
                    state_reg <= S_V_MUL;
                end
                S_V_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_V_ACC;
                end
                S_V_ACC:
                begin
                    if (msel_reg == 2'd2)
                    begin
                        idx_reg <= idx_inc;
                        if (idx_last)
                        begin
                            num_reg   <= acc_reg + acc_add;
                            rem_reg   <= '0;
                            dcnt_reg  <= '0;
                            var_reg   <= 1'b1;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            acc_reg   <= acc_reg + acc_add;
                            state_reg <= S_V_RD;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_reg + acc_add;
                        msel_reg  <= msel_reg + 2'd1;
                        state_reg <= S_V_MUL;
                    end
                end
                S_SQRT:
                begin
                    num_reg  <= num_reg << 2;
                    srem_reg <= sq_ge ? sq_r - sq_trial : sq_r;
                    root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (dcnt_reg == 7'(ROOT_W - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_OK;
                        out_count_reg  <= COUNT_W'(held_reg);
                        out_min_reg    <= min_reg;
                        out_max_reg    <= max_reg;
                        out_mean_reg   <= mean_reg;
                        out_med_reg    <= med_sum[DUR_W:1];
                        out_sd_reg     <= root_reg[DUR_W-1:0];
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.lap_count = out_count_reg;
    assign rsp.min_ns    = out_min_reg;
    assign rsp.max_ns    = out_max_reg;
    assign rsp.mean_ns   = out_mean_reg;
    assign rsp.median_ns = out_med_reg;
    assign rsp.stddev_ns = out_sd_reg;
endmodule

FILE: hw/rtl/lts_checker.sv
// Port-level checker for the lap timer, bound to the top level
`include "lap_time_statistics_core_assert.svh"
module lts_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [1:0]               rsp_status,
    input logic [lts_pkg::COUNT_W-1:0] rsp_lap_count,
    input logic [lts_pkg::DUR_W-1:0]   rsp_min_ns,
    input logic [lts_pkg::DUR_W-1:0]   rsp_max_ns,
    input logic [lts_pkg::DUR_W-1:0]   rsp_stddev_ns
);
    import lts_pkg::*;

    `LTS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `LTS_ASSERT_SAME(a_status_code, clk, rst_n, rsp_valid, rsp_status != 2'd3)
    `LTS_ASSERT_SAME(a_ok_has_laps, clk, rst_n, rsp_valid && rsp_status == ST_OK, rsp_lap_count != '0)
    `LTS_ASSERT_SAME(a_min_le_max, clk, rst_n, rsp_valid && rsp_status == ST_OK, rsp_min_ns <= rsp_max_ns)
    `LTS_ASSERT_SAME(a_err_zeroed, clk, rst_n, rsp_valid && rsp_status != ST_OK, rsp_min_ns == '0 && rsp_stddev_ns == '0)
endmodule

bind lap_time_statistics_core lts_checker u_lts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_lap_count (rsp.lap_count),
    .rsp_min_ns    (rsp.min_ns),
    .rsp_max_ns    (rsp.max_ns),
    .rsp_stddev_ns (rsp.stddev_ns)
);
